[sv/mapt_pkg.sv]
package mapt_pkg;

    localparam int MAC_W   = 48;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DUPLICATE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [MAC_W-1:0] mac_addr;
    } mapt_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  slot_index;
        logic [COUNT_W-1:0] entry_count;
    } mapt_rsp_t;

    typedef struct packed {
        logic             capture;
        logic             add_en;
        logic             remove_en;
        logic [MAC_W-1:0] key;
    } mapt_ctrl_t;

endpackage

[sv/mapt_cell.sv]
module mapt_cell #(
    parameter int SLOT    = 0,
    parameter int IDX_W   = 4,
    parameter int CNT_W   = 5
) (
    input  logic                  clk,
    input  mapt_pkg::mapt_ctrl_t  ctrl,
    input  logic [CNT_W-1:0]      count,
    input  logic [IDX_W-1:0]      hit_idx,
    input  logic [47:0]           upper_entry,
    output logic [47:0]           entry,
    output logic                  match
);
    import mapt_pkg::*;

    localparam logic [CNT_W-1:0] SLOT_C = CNT_W'(SLOT);
    localparam logic [IDX_W-1:0] SLOT_I = IDX_W'(SLOT);

    logic [MAC_W-1:0] entry_reg;
    logic [MAC_W-1:0] entry_next;
    logic             match_reg;
    logic             match_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.add_en && (SLOT_C == count))
        begin
            entry_next = ctrl.key;
        end
        else if (ctrl.remove_en && (SLOT_I >= hit_idx))
        begin
            entry_next = upper_entry;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.capture)
        begin
            match_next = (entry_reg == ctrl.key) && (SLOT_C < count);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

[sv/mapt_hit_encode.sv]
module mapt_hit_encode #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic [DEPTH-1:0] match,
    output logic             found,
    output logic [IDX_W-1:0] hit_idx
);
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_idx = hit_idx | (match[i] ? IDX_W'(i) : IDX_W'(0));
        end
    end

    assign found = |match;

endmodule

[sv/mac_address_peer_table.sv]
// Table of up to TABLE_DEPTH 48-bit MAC addresses kept packed from slot 0 in the
// order they were added. Each request beat adds, removes or looks up one address
// and yields one response beat with status, slot and entry count. Every slot is a
// cell that compares its entry against the key in the cycle the request is taken
// and, on remove, copies its upper neighbor so later entries close the gap. A
// request is handled in two steps: the parallel compare, then the hit resolve and
// cell update, which waits while a previous response is unaccepted; the next
// request is taken once the update is done, while the response may still wait in
// its output register. Only count, state and rsp_valid reset; entries do not.
module mac_address_peer_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  mapt_pkg::mapt_req_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output mapt_pkg::mapt_rsp_t  rsp
);
    import mapt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [MAC_W-1:0] key_reg, key_next;
    logic             rsp_valid_reg, rsp_valid_next;
    mapt_rsp_t        rsp_reg, rsp_next;

    mapt_ctrl_t       ctrl;
    logic [TABLE_DEPTH-1:0] match;
    logic [MAC_W-1:0] entries [TABLE_DEPTH];
    logic [MAC_W-1:0] uppers  [TABLE_DEPTH];
    logic             found;
    logic [IDX_W-1:0] hit_idx;
    logic             go;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0] slot;

    assign req_ready = (state_reg == S_IDLE);
    assign go        = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        status         = STAT_OK;
        slot           = '0;
        count_next     = count_reg;
        ctrl.capture   = req_valid && req_ready;
        ctrl.add_en    = 1'b0;
        ctrl.remove_en = 1'b0;
        ctrl.key       = ctrl.capture ? req.mac_addr : key_reg;
        case (op_reg)
            OP_ADD:
            begin
                if (found)
                begin
                    status = STAT_DUPLICATE;
                end
                else if (count_reg >= DEPTH_C)
                begin
                    status = STAT_FULL;
                end
                else
                begin
                    slot        = IDX_W'(count_reg);
                    ctrl.add_en = go;
                    count_next  = go ? count_reg + 1'b1 : count_reg;
                end
            end
            OP_REMOVE:
            begin
                if (found)
                begin
                    slot           = hit_idx;
                    ctrl.remove_en = go;
                    count_next     = go ? count_reg - 1'b1 : count_reg;
                end
                else
                begin
                    status = STAT_NOT_FOUND;
                end
            end
            default:
            begin
                if (found)
                begin
                    slot = hit_idx;
                end
                else
                begin
                    status = STAT_NOT_FOUND;
                end
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctrl.capture)
                begin
                    op_next    = req.op;
                    key_next   = req.mac_addr;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (go)
                begin
                    rsp_next.status      = status;
                    rsp_next.slot_index  = SLOT_W'(slot);
                    rsp_next.entry_count = COUNT_W'(count_next);
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        key_reg <= key_next;
        rsp_reg <= rsp_next;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        if (g == TABLE_DEPTH - 1)
        begin : g_last
            assign uppers[g] = entries[g];
        end
        else
        begin : g_mid
            assign uppers[g] = entries[g+1];
        end

        mapt_cell #(
            .SLOT  (g),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .hit_idx     (hit_idx),
            .upper_entry (uppers[g]),
            .entry       (entries[g]),
            .match       (match[g])
        );
    end

    mapt_hit_encode #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_hit_encode (
        .match   (match),
        .found   (found),
        .hit_idx (hit_idx)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
